@@ hdl/pno_pkg.sv @@
// Shared constants for the fractal Perlin noise block: permutation table,
// multiplier widths, configuration register indexes and reset values.
// No dependencies.
package pno_pkg;

	localparam int PNO_MAX_OCTAVES   = 8;
	localparam int PNO_FRACTION_BITS = 16;

	localparam int PNO_MUL_A_W = 33;
	localparam int PNO_MUL_B_W = 25;
	localparam int PNO_MUL_P_W = PNO_MUL_A_W + PNO_MUL_B_W;

	localparam int PNO_QUOT_BITS = 20;

	localparam logic [1:0] REG_BASE_FREQ   = 2'd0;
	localparam logic [1:0] REG_OCTAVES     = 2'd1;
	localparam logic [1:0] REG_PERSISTENCE = 2'd2;

	localparam logic [23:0] BASE_FREQ_RST   = 24'd65536;
	localparam logic [3:0]  OCTAVES_RST     = 4'd4;
	localparam logic [16:0] PERSISTENCE_RST = 17'd32768;

	localparam logic [7:0] PERM [256] = '{
		8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
		8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
		8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
		8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
		8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
		8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
		8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
		8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
		8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
		8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
		8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
		8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
		8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
		8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
		8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
		8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
		8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
		8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
		8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
		8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
		8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
		8'd215,8'd61,8'd156,8'd180
	};

endpackage

@@ hdl/pno_mul.sv @@
// Shared signed multiplier with registered product.
// Depends on pno_pkg.
module pno_mul (
	input  logic                                  clk,
	input  logic signed [pno_pkg::PNO_MUL_A_W-1:0] a,
	input  logic signed [pno_pkg::PNO_MUL_B_W-1:0] b,
	output logic signed [pno_pkg::PNO_MUL_P_W-1:0] p
);
	import pno_pkg::*;

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

@@ hdl/pno_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on pno_pkg.
module pno_div #(
	parameter int DW = 57
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [DW-1:0]                      num,
	input  logic [DW-1:0]                      den,
	output logic                               done,
	output logic [pno_pkg::PNO_QUOT_BITS-1:0]  quot
);
	import pno_pkg::*;

	localparam int CW = $clog2(PNO_QUOT_BITS);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsh_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [PNO_QUOT_BITS-1:0] quot_q;
	logic          ge;

	assign ge   = rem_q >= dsh_q;
	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(PNO_QUOT_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsh_q  <= den << (PNO_QUOT_BITS - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[PNO_QUOT_BITS-2:0], ge};
		end
	end

endmodule

@@ hdl/perlin_noise_3d_octaves_top.sv @@
// Fractal 3D Perlin noise: sequencer, octave datapath and output register.
// Depends on pno_pkg, pno_mul and pno_div.
//
// One point is taken at a time; in_ready is low while it is worked on. Each
// octave steps through scaling, fade, permutation lookups, interpolation,
// accumulation and amplitude update, all multiplies going through one shared
// multiplier and all hashing through one permutation table read per cycle.
// After the last octave a one-bit-per-cycle divider divides the weighted sum
// by the total weight. The result sits in an output register, so the next
// point can be taken while it waits for transfer.
module perlin_noise_3d_octaves_top #(
	parameter int MAX_OCTAVES   = pno_pkg::PNO_MAX_OCTAVES,
	parameter int FRACTION_BITS = pno_pkg::PNO_FRACTION_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] x_coord,
	input  logic [31:0] y_coord,
	input  logic [31:0] z_coord,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [16:0] noise_value
);
	import pno_pkg::*;

	localparam int F   = FRACTION_BITS;
	localparam int FW4 = F + 4;
	localparam int GW  = F + 3;
	localparam int LW  = F + 3;
	localparam int LW1 = LW + 1;
	localparam int TW  = F + 24;
	localparam int DW  = F + 41;
	localparam int OW  = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
	localparam int MA  = PNO_MUL_A_W;
	localparam int MB  = PNO_MUL_B_W;
	localparam int MP  = PNO_MUL_P_W;

	localparam logic [FW4-1:0] S4   = FW4'(1) << F;
	localparam logic [FW4-1:0] C15S = FW4'(15) << F;
	localparam logic [FW4-1:0] C10S = FW4'(10) << F;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SCALE = 4'd1;
	localparam logic [3:0] ST_FADE  = 4'd2;
	localparam logic [3:0] ST_HASH  = 4'd3;
	localparam logic [3:0] ST_LERP  = 4'd4;
	localparam logic [3:0] ST_ACC   = 4'd5;
	localparam logic [3:0] ST_AMP   = 4'd6;
	localparam logic [3:0] ST_DIV   = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	function automatic logic signed [GW-1:0] grad_f(
		input logic [3:0] h,
		input logic signed [GW-1:0] x,
		input logic signed [GW-1:0] y,
		input logic signed [GW-1:0] z
	);
		logic signed [GW-1:0] g;
		case (h)
			4'h0: g = x + y;
			4'h1: g = -x + y;
			4'h2: g = x - y;
			4'h3: g = -x - y;
			4'h4: g = x + z;
			4'h5: g = -x + z;
			4'h6: g = x - z;
			4'h7: g = -x - z;
			4'h8: g = y + z;
			4'h9: g = -y + z;
			4'hA: g = y - z;
			4'hB: g = -y - z;
			4'hC: g = y + x;
			4'hD: g = -y + z;
			4'hE: g = y - x;
			default: g = -y - z;
		endcase
		return g;
	endfunction

	// configuration
	logic [23:0] bf_q;
	logic [3:0]  oc_q;
	logic [16:0] pers_q;
	logic [16:0] pers_sat;

	// sequencer
	logic [3:0]    state_q;
	logic          ph_q;
	logic [1:0]    k_q;
	logic [1:0]    j_q;
	logic [3:0]    h_q;
	logic [2:0]    li_q;
	logic [OW-1:0] oct_q;
	logic [4:0]    n_q;

	// datapath
	logic [31:0]            c_q [3];
	logic [7:0]             ip_q [3];
	logic [F-1:0]           fr_q [3];
	logic [F:0]             fd_q [3];
	logic [F-1:0]           t2_q;
	logic [F-1:0]           t3_q;
	logic [F+3:0]           e_q;
	logic [7:0]             ha_q [2];
	logic [7:0]             hb_q [4];
	logic [3:0]             hc_q [8];
	logic signed [LW-1:0]   lr_q [7];
	logic [16:0]            amp_q;
	logic [20:0]            wt_q;
	logic signed [TW-1:0]   tot_q;
	logic                   out_valid_q;
	logic [16:0]            noise_q;

	logic signed [MA-1:0] ma;
	logic signed [MB-1:0] mb;
	logic signed [MP-1:0] mp;
	logic [63:0]          p64;
	logic [F-1:0]         t;
	logic [7:0]           rom_addr;
	logic [7:0]           rom_data;
	logic [1:0]           hj;
	logic [2:0]           hk;
	logic signed [GW-1:0] xo [3];
	logic signed [GW-1:0] xl [3];
	logic signed [GW-1:0] gv [8];
	logic signed [LW-1:0] la;
	logic signed [LW-1:0] lb;
	logic [F:0]           lw;
	logic signed [FW4-1:0] ldiff;
	logic signed [LW-1:0] lres;
	logic signed [LW1-1:0] vsum;
	logic                 last_oct;
	logic                 div_start;
	logic                 div_done;
	logic [DW-1:0]        div_num;
	logic [DW-1:0]        div_den;
	logic [PNO_QUOT_BITS-1:0] div_quot;
	logic [4:0]           n_clamp;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign noise_value = noise_q;
	assign pers_sat    = (pers_q > 17'd65536) ? 17'd65536 : pers_q;

	assign t        = fr_q[k_q];
	assign p64      = 64'(mp[55:0]) << oct_q;
	assign hj       = 2'(h_q - 4'd2);
	assign hk       = 3'(h_q - 4'd6);
	assign rom_data = PERM[rom_addr];
	assign last_oct = (5'(oct_q) == n_q - 5'd1);
	assign div_start = (state_q == ST_AMP) && ph_q && last_oct;
	assign div_num  = (tot_q > 0) ? (DW'(tot_q) << 16) : '0;
	assign div_den  = DW'(wt_q) << F;
	assign vsum     = LW1'(lr_q[6]) + LW1'(S4);
	assign ldiff    = FW4'(lb) - FW4'(la);
	assign lres     = la + LW'(mp >>> F);

	assign n_clamp = (oc_q == 4'd0) ? 5'd1 :
		((5'(oc_q) > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : 5'(oc_q));

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			xo[i] = GW'(fr_q[i]);
			xl[i] = xo[i] - GW'(S4);
		end
		for (int c = 0; c < 8; c++) begin
			gv[c] = grad_f(hc_q[c], c[0] ? xl[0] : xo[0], c[1] ? xl[1] : xo[1],
				c[2] ? xl[2] : xo[2]);
		end
	end

	always_comb begin
		if (h_q < 4'd2) begin
			rom_addr = ip_q[0] + 8'(h_q[0]);
		end else if (h_q < 4'd6) begin
			rom_addr = ha_q[hj[0]] + ip_q[1] + 8'(hj[1]);
		end else begin
			rom_addr = hb_q[hk[1:0]] + ip_q[2] + 8'(hk[2]);
		end
	end

	always_comb begin
		case (li_q)
			3'd0: begin la = gv[0];   lb = gv[1];   lw = fd_q[0]; end
			3'd1: begin la = gv[2];   lb = gv[3];   lw = fd_q[0]; end
			3'd2: begin la = lr_q[0]; lb = lr_q[1]; lw = fd_q[1]; end
			3'd3: begin la = gv[4];   lb = gv[5];   lw = fd_q[0]; end
			3'd4: begin la = gv[6];   lb = gv[7];   lw = fd_q[0]; end
			3'd5: begin la = lr_q[3]; lb = lr_q[4]; lw = fd_q[1]; end
			3'd6: begin la = lr_q[2]; lb = lr_q[5]; lw = fd_q[2]; end
			default: begin la = '0; lb = '0; lw = '0; end
		endcase
	end

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_SCALE: begin
				ma = MA'(c_q[k_q]);
				mb = MB'(bf_q);
			end
			ST_FADE: begin
				case (j_q)
					2'd0: begin ma = MA'(t); mb = MB'(t); end
					2'd1: begin ma = MA'(C15S - FW4'(t) * FW4'(6)); mb = MB'(t); end
					2'd2: begin ma = MA'(t); mb = MB'(t2_q); end
					default: begin ma = MA'(C10S - e_q); mb = MB'(t3_q); end
				endcase
			end
			ST_LERP: begin
				ma = MA'(ldiff);
				mb = MB'(lw);
			end
			ST_ACC: begin
				ma = MA'(vsum >>> 1);
				mb = MB'(amp_q);
			end
			ST_AMP: begin
				ma = MA'(amp_q);
				mb = MB'(pers_sat);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	pno_mul u_mul (
		.clk (clk),
		.a   (ma),
		.b   (mb),
		.p   (mp)
	);

	pno_div #(.DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bf_q   <= BASE_FREQ_RST;
			oc_q   <= OCTAVES_RST;
			pers_q <= PERSISTENCE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BASE_FREQ:   bf_q   <= cfg_wr_data;
				REG_OCTAVES:     oc_q   <= cfg_wr_data[3:0];
				REG_PERSISTENCE: pers_q <= cfg_wr_data[16:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_q        <= 1'b0;
			k_q         <= '0;
			j_q         <= '0;
			h_q         <= '0;
			li_q        <= '0;
			oct_q       <= '0;
			n_q         <= 5'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SCALE;
						n_q     <= n_clamp;
						oct_q   <= '0;
						k_q     <= '0;
						ph_q    <= 1'b0;
					end
				end
				ST_SCALE: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (k_q == 2'd2) begin
							k_q     <= '0;
							j_q     <= '0;
							state_q <= ST_FADE;
						end else begin
							k_q <= k_q + 2'd1;
						end
					end
				end
				ST_FADE: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						j_q <= j_q + 2'd1;
						if (j_q == 2'd3) begin
							if (k_q == 2'd2) begin
								k_q     <= '0;
								h_q     <= '0;
								state_q <= ST_HASH;
							end else begin
								k_q <= k_q + 2'd1;
							end
						end
					end
				end
				ST_HASH: begin
					h_q <= h_q + 4'd1;
					if (h_q == 4'd13) begin
						li_q    <= '0;
						ph_q    <= 1'b0;
						state_q <= ST_LERP;
					end
				end
				ST_LERP: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						li_q <= li_q + 3'd1;
						if (li_q == 3'd6) begin
							state_q <= ST_ACC;
						end
					end
				end
				ST_ACC: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						state_q <= ST_AMP;
					end
				end
				ST_AMP: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (last_oct) begin
							state_q <= ST_DIV;
						end else begin
							oct_q   <= oct_q + OW'(1);
							k_q     <= '0;
							state_q <= ST_SCALE;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				c_q[0] <= x_coord;
				c_q[1] <= y_coord;
				c_q[2] <= z_coord;
				amp_q  <= 17'd65536;
				wt_q   <= '0;
				tot_q  <= '0;
			end
			ST_SCALE: begin
				if (ph_q) begin
					ip_q[k_q] <= p64[39:32];
					fr_q[k_q] <= p64[31 -: F];
				end
			end
			ST_FADE: begin
				if (ph_q) begin
					case (j_q)
						2'd0: t2_q <= mp[2*F-1:F];
						2'd1: e_q  <= mp[2*F+3:F];
						2'd2: t3_q <= mp[2*F-1:F];
						default: fd_q[k_q] <= mp[2*F:F];
					endcase
				end
			end
			ST_HASH: begin
				if (h_q < 4'd2) begin
					ha_q[h_q[0]] <= rom_data;
				end else if (h_q < 4'd6) begin
					hb_q[hj] <= rom_data;
				end else begin
					hc_q[hk] <= rom_data[3:0];
				end
			end
			ST_LERP: begin
				if (ph_q) begin
					lr_q[li_q] <= lres;
				end
			end
			ST_ACC: begin
				if (ph_q) begin
					tot_q <= tot_q + TW'(mp);
					wt_q  <= wt_q + 21'(amp_q);
				end
			end
			ST_AMP: begin
				if (ph_q) begin
					amp_q <= mp[32:16];
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					noise_q <= (div_quot > PNO_QUOT_BITS'(65536)) ? 17'd65536 :
						div_quot[16:0];
				end
			end
			default: ;
		endcase
	end

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> noise_value <= 17'd65536)
		else $error("noise value out of range");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready while a point is in flight");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the division step");

endmodule
